>>> rtl/core/swrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swrb_pkg
// Shared types and constants of the stop-and-wait sender with binary
// exponential backoff.
// ----------------------------------------------------------------------------
package swrb_pkg;

  // Retry and backoff limits
  localparam logic [3:0] RETRY_LIMIT = 4'd10;
  localparam logic [3:0] BACKOFF_CAP = 4'd10;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int LEN_W   = 16;
  localparam int NUM_W   = 32;
  localparam int RND_W   = 10;
  localparam int CNT4_W  = 4;
  localparam int TMO_W   = 24;
  localparam int SLOT_W  = 16;
  localparam int CFG_W   = 24;
  // Widest wait: max(timeout, 1023 * 65535) fits in 26 bits
  localparam int WAIT_W  = 26;

  // Input item kinds
  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SLOT    = 1'b1;

  // Result actions
  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_DELIVER = 2'd1,
    ACT_BACKOFF = 2'd2,
    ACT_ABORT   = 2'd3
  } action_t;

endpackage
`default_nettype wire

>>> rtl/core/stop_wait_retry_backoff_sender.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stop_wait_retry_backoff_sender
// Stop-and-wait ARQ sender with truncated binary exponential backoff.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  mode, frame_length, ack_id, random
//  out_     output     out_valid / out_stall action, frame, stats
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled: an input
// register feeds one pass of state update logic whose result lands in the
// output register. The slot multiply (10 x 16) sets the longest path. Reset
// is synchronous; all state and config return to their reset values. A
// stalled result holds the input register, which then stalls the input
// channel; configuration is always ready.
// ----------------------------------------------------------------------------
module stop_wait_retry_backoff_sender
  import swrb_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  // input items
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [MODE_W-1:0]   in_mode,
  input  wire  [LEN_W-1:0]    in_frame_length,
  input  wire  [NUM_W-1:0]    in_ack_id,
  input  wire  [RND_W-1:0]    in_random_value,
  // result items
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          out_action,
  output logic [NUM_W-1:0]    out_frame_number,
  output logic [LEN_W-1:0]    out_payload_bytes,
  output logic [CNT4_W-1:0]   out_attempt_count,
  output logic [RND_W-1:0]    out_backoff_slots,
  output logic [NUM_W-1:0]    out_frames_done,
  output logic [NUM_W-1:0]    out_bytes_done,
  output logic [NUM_W-1:0]    out_sends_total,
  output logic [CNT4_W-1:0]   out_sends_max,
  // configuration
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire                 cfg_index,
  input  wire  [CFG_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_BACKOFF = 2'd2,
    PH_ABORT   = 2'd3
  } phase_t;

  // input register
  logic               pipe_valid_r;
  logic [MODE_W-1:0]  p_mode_r;
  logic [LEN_W-1:0]   p_len_r;
  logic [NUM_W-1:0]   p_ack_r;
  logic [RND_W-1:0]   p_rnd_r;

  // sender state
  phase_t             phase_r, phase_nxt;
  logic [NUM_W-1:0]   frame_r, frame_nxt;
  logic [CNT4_W-1:0]  fail_r, fail_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [NUM_W-1:0]   dfr_r, dfr_nxt;
  logic [NUM_W-1:0]   dby_r, dby_nxt;
  logic [NUM_W-1:0]   dsum_r, dsum_nxt;
  logic [CNT4_W-1:0]  dpeak_r, dpeak_nxt;

  // configuration
  logic [TMO_W-1:0]   tmo_r;
  logic [SLOT_W-1:0]  slot_r;

  // result register
  logic               out_valid_r;
  action_t            out_action_r;
  logic [NUM_W-1:0]   out_frame_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [CNT4_W-1:0]  out_att_r;
  logic [RND_W-1:0]   out_slots_r;
  logic [NUM_W-1:0]   out_dfr_r;
  logic [NUM_W-1:0]   out_dby_r;
  logic [NUM_W-1:0]   out_dsum_r;
  logic [CNT4_W-1:0]  out_dpeak_r;

  // pass control
  logic               out_free;
  logic               proc;
  logic               emit;
  action_t            act;
  logic [RND_W-1:0]   slots_out;

  // backoff draw and wait timing
  logic [CNT4_W-1:0]  fail_inc;
  logic [CNT4_W-1:0]  sends;
  logic [CNT4_W-1:0]  bits;
  logic [RND_W-1:0]   mask;
  logic [RND_W-1:0]   slots_draw;
  logic [WAIT_W-1:0]  backoff_wait;
  logic [WAIT_W-1:0]  wait_dec;
  logic               expire;

  // handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign proc      = pipe_valid_r && out_free;
  assign in_stall  = pipe_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  // failure draw: mask random value to min(failures, cap) low bits
  assign fail_inc   = fail_r + 4'd1;
  assign sends      = fail_r + 4'd1;
  assign bits       = (fail_inc < BACKOFF_CAP) ? fail_inc : BACKOFF_CAP;
  always_comb begin
    for (int i = 0; i < RND_W; i++) begin
      mask[i] = (CNT4_W'(i) < bits);
    end
  end
  assign slots_draw   = p_rnd_r & mask;
  assign backoff_wait = {{(WAIT_W-SLOT_W){1'b0}}, slot_r} *
                        {{(WAIT_W-RND_W){1'b0}}, slots_draw};

  // tick: count down, expire on reaching zero
  assign wait_dec = (wait_r == '0) ? '0 : wait_r - WAIT_W'(1);
  assign expire   = (wait_dec == '0);

  // next state and result of one item
  always_comb begin
    phase_nxt = phase_r;
    frame_nxt = frame_r;
    fail_nxt  = fail_r;
    wait_nxt  = wait_r;
    len_nxt   = len_r;
    dfr_nxt   = dfr_r;
    dby_nxt   = dby_r;
    dsum_nxt  = dsum_r;
    dpeak_nxt = dpeak_r;
    emit      = 1'b0;
    act       = ACT_SEND;
    slots_out = '0;
    if (proc) begin
      case (p_mode_r)
        MODE_FRAME: begin
          if (phase_r == PH_IDLE && p_len_r != '0) begin
            len_nxt   = p_len_r;
            fail_nxt  = '0;
            phase_nxt = PH_WAIT;
            wait_nxt  = {{(WAIT_W-TMO_W){1'b0}}, tmo_r};
            emit      = 1'b1;
            act       = ACT_SEND;
          end
        end
        MODE_ACK: begin
          if (phase_r == PH_WAIT) begin
            emit = 1'b1;
            if (p_ack_r != frame_r) begin
              fail_nxt  = fail_inc;
              phase_nxt = PH_BACKOFF;
              wait_nxt  = backoff_wait;
              act       = ACT_BACKOFF;
              slots_out = slots_draw;
            end else begin
              dfr_nxt   = dfr_r + NUM_W'(1);
              dby_nxt   = dby_r + {{(NUM_W-LEN_W){1'b0}}, len_r};
              dsum_nxt  = dsum_r + {{(NUM_W-CNT4_W){1'b0}}, sends};
              dpeak_nxt = (sends > dpeak_r) ? sends : dpeak_r;
              phase_nxt = PH_IDLE;
              frame_nxt = frame_r + NUM_W'(1);
              act       = ACT_DELIVER;
            end
          end
        end
        MODE_TICK: begin
          if (phase_r inside {PH_WAIT, PH_BACKOFF}) begin
            wait_nxt = wait_dec;
            if (expire) begin
              emit = 1'b1;
              if (phase_r == PH_WAIT) begin
                fail_nxt  = fail_inc;
                phase_nxt = PH_BACKOFF;
                wait_nxt  = backoff_wait;
                act       = ACT_BACKOFF;
                slots_out = slots_draw;
              end else if (fail_r >= RETRY_LIMIT) begin
                phase_nxt = PH_ABORT;
                act       = ACT_ABORT;
              end else begin
                phase_nxt = PH_WAIT;
                wait_nxt  = {{(WAIT_W-TMO_W){1'b0}}, tmo_r};
                act       = ACT_SEND;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state, config, input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_IDLE;
      frame_r      <= '0;
      fail_r       <= '0;
      wait_r       <= '0;
      len_r        <= '0;
      dfr_r        <= '0;
      dby_r        <= '0;
      dsum_r       <= '0;
      dpeak_r      <= '0;
      tmo_r        <= TMO_W'(1000);
      slot_r       <= SLOT_W'(10);
    end else begin
      // input register
      if (!in_stall) begin
        pipe_valid_r <= in_valid;
      end
      if (in_valid && !in_stall) begin
        p_mode_r <= in_mode;
        p_len_r  <= in_frame_length;
        p_ack_r  <= in_ack_id;
        p_rnd_r  <= in_random_value;
      end
      // state update
      phase_r <= phase_nxt;
      frame_r <= frame_nxt;
      fail_r  <= fail_nxt;
      wait_r  <= wait_nxt;
      len_r   <= len_nxt;
      dfr_r   <= dfr_nxt;
      dby_r   <= dby_nxt;
      dsum_r  <= dsum_nxt;
      dpeak_r <= dpeak_nxt;
      // result slot
      if (out_free) begin
        out_valid_r <= proc && emit;
      end
      if (proc && emit) begin
        out_action_r <= act;
        out_frame_r  <= frame_r;
        out_len_r    <= len_nxt;
        out_att_r    <= fail_nxt;
        out_slots_r  <= slots_out;
        out_dfr_r    <= dfr_nxt;
        out_dby_r    <= dby_nxt;
        out_dsum_r   <= dsum_nxt;
        out_dpeak_r  <= dpeak_nxt;
      end
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT: tmo_r  <= cfg_data[TMO_W-1:0];
          CFG_SLOT:    slot_r <= cfg_data[SLOT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_frame_number  = out_frame_r;
  assign out_payload_bytes = out_len_r;
  assign out_attempt_count = out_att_r;
  assign out_backoff_slots = out_slots_r;
  assign out_frames_done   = out_dfr_r;
  assign out_bytes_done    = out_dby_r;
  assign out_sends_total   = out_dsum_r;
  assign out_sends_max     = out_dpeak_r;

  // checks
  a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ABORT |=> phase_r == PH_ABORT)
    else $error("abort state left before reset");

  a_slots_only_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_action_r != ACT_BACKOFF |-> out_slots_r == '0)
    else $error("backoff slots on a result that is not a backoff");

  a_attempt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_att_r <= RETRY_LIMIT && out_dpeak_r <= RETRY_LIMIT)
    else $error("attempt count or peak sends beyond retry limit");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_action_r))
    else $error("stalled result changed or was dropped");

endmodule
`default_nettype wire

>>> tb/stop_wait_retry_backoff_sender_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_wait_retry_backoff_sender_test
// Self-checking bench for the stop-and-wait sender. It keeps its own copy of
// the link state and statistics, predicts the result of every item the
// block accepts and checks each result the block hands out. Directed cases
// cover the corners; random frame, ack and tick traffic follows under a
// series of timeout and slot settings, and the run ends by driving the link
// into its sticky abort.
// ----------------------------------------------------------------------------
module stop_wait_retry_backoff_sender_test;
  import swrb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASES       = 8;
  localparam int DRAIN_CYCLES = 6;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    ST_IDLE, ST_AWAIT_ACK, ST_BACKOFF, ST_ABORTED
  } link_state_t;

  typedef struct {
    action_t           action;
    logic [NUM_W-1:0]  frame_number;
    logic [LEN_W-1:0]  payload_bytes;
    logic [CNT4_W-1:0] attempt_count;
    logic [RND_W-1:0]  backoff_slots;
    logic [NUM_W-1:0]  frames_done;
    logic [NUM_W-1:0]  bytes_done;
    logic [NUM_W-1:0]  sends_total;
    logic [CNT4_W-1:0] sends_max;
  } link_report_t;

  // DUT connections
  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode;
  logic [LEN_W-1:0]  in_frame_length;
  logic [NUM_W-1:0]  in_ack_id;
  logic [RND_W-1:0]  in_random_value;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_action;
  logic [NUM_W-1:0]  out_frame_number;
  logic [LEN_W-1:0]  out_payload_bytes;
  logic [CNT4_W-1:0] out_attempt_count;
  logic [RND_W-1:0]  out_backoff_slots;
  logic [NUM_W-1:0]  out_frames_done;
  logic [NUM_W-1:0]  out_bytes_done;
  logic [NUM_W-1:0]  out_sends_total;
  logic [CNT4_W-1:0] out_sends_max;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // Predicted link state and statistics
  link_state_t       link_state;
  logic [NUM_W-1:0]  frame_seq;
  logic [CNT4_W-1:0] fail_cnt;
  logic [31:0]       ticks_left;
  logic [LEN_W-1:0]  frame_len;
  logic [NUM_W-1:0]  n_delivered;
  logic [NUM_W-1:0]  bytes_delivered;
  logic [NUM_W-1:0]  tx_sum;
  logic [CNT4_W-1:0] tx_peak;
  logic [TMO_W-1:0]  timeout_setting;
  logic [SLOT_W-1:0] slot_setting;

  link_report_t link_reports[$];
  int           mismatch_count = 0;
  bit           no_gaps = 1'b0;
  bit           hold_off_req = 1'b0;

  stop_wait_retry_backoff_sender dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_frame_length   (in_frame_length),
    .in_ack_id         (in_ack_id),
    .in_random_value   (in_random_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_frame_number  (out_frame_number),
    .out_payload_bytes (out_payload_bytes),
    .out_attempt_count (out_attempt_count),
    .out_backoff_slots (out_backoff_slots),
    .out_frames_done   (out_frames_done),
    .out_bytes_done    (out_bytes_done),
    .out_sends_total   (out_sends_total),
    .out_sends_max     (out_sends_max),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Link prediction
  // --------------------------------------------------------------------------
  task automatic push_report(input action_t act, input logic [RND_W-1:0] slots);
    link_report_t rep;
    rep.action        = act;
    rep.frame_number  = frame_seq;
    rep.payload_bytes = frame_len;
    rep.attempt_count = fail_cnt;
    rep.backoff_slots = slots;
    rep.frames_done   = n_delivered;
    rep.bytes_done    = bytes_delivered;
    rep.sends_total   = tx_sum;
    rep.sends_max     = tx_peak;
    link_reports.push_back(rep);
  endtask

  task automatic begin_send();
    link_state = ST_AWAIT_ACK;
    ticks_left = 32'(timeout_setting);
    push_report(ACT_SEND, '0);
  endtask

  // Failure: bump the count, draw slots from the low min(failures, cap) bits
  task automatic note_failure(input logic [RND_W-1:0] rnd);
    logic [3:0]       nbits;
    logic [31:0]      mask;
    logic [RND_W-1:0] slots;
    fail_cnt = fail_cnt + 4'd1;
    nbits = (fail_cnt < BACKOFF_CAP) ? fail_cnt : BACKOFF_CAP;
    mask = (32'd1 << nbits) - 32'd1;
    slots = RND_W'(32'(rnd) & mask);
    link_state = ST_BACKOFF;
    ticks_left = 32'(slots) * 32'(slot_setting);
    push_report(ACT_BACKOFF, slots);
  endtask

  task automatic advance_link(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] flen,
                              input logic [NUM_W-1:0] ack, input logic [RND_W-1:0] rnd);
    logic [CNT4_W-1:0] sends;
    if (link_state == ST_ABORTED) return;
    case (mode)
      MODE_FRAME: begin
        if (link_state == ST_IDLE && flen != '0) begin
          frame_len = flen;
          fail_cnt = '0;
          begin_send();
        end
      end
      MODE_ACK: begin
        if (link_state == ST_AWAIT_ACK) begin
          if (ack != frame_seq) begin
            note_failure(rnd);
          end else begin
            sends = fail_cnt + 4'd1;
            n_delivered = n_delivered + 1;
            bytes_delivered = bytes_delivered + 32'(frame_len);
            tx_sum = tx_sum + 32'(sends);
            if (sends > tx_peak) tx_peak = sends;
            link_state = ST_IDLE;
            push_report(ACT_DELIVER, '0);
            frame_seq = frame_seq + 1;
          end
        end
      end
      MODE_TICK: begin
        if (link_state == ST_AWAIT_ACK || link_state == ST_BACKOFF) begin
          if (ticks_left != 0) ticks_left = ticks_left - 1;
          if (ticks_left == 0) begin
            if (link_state == ST_AWAIT_ACK) begin
              note_failure(rnd);
            end else if (fail_cnt >= RETRY_LIMIT) begin
              link_state = ST_ABORTED;
              push_report(ACT_ABORT, '0);
            end else begin
              begin_send();
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch in %0s: expected %0h, actual %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    link_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (link_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result with none pending: action %0d frame %0h", out_action,
                   out_frame_number);
      end else begin
        want = link_reports.pop_front();
        check_field("action",        32'(want.action),        32'(out_action));
        check_field("frame_number",  want.frame_number,       out_frame_number);
        check_field("payload_bytes", 32'(want.payload_bytes), 32'(out_payload_bytes));
        check_field("attempt_count", 32'(want.attempt_count), 32'(out_attempt_count));
        check_field("backoff_slots", 32'(want.backoff_slots), 32'(out_backoff_slots));
        check_field("frames_done",   want.frames_done,        out_frames_done);
        check_field("bytes_done",    want.bytes_done,         out_bytes_done);
        check_field("sends_total",   want.sends_total,        out_sends_total);
        check_field("sends_max",     32'(want.sends_max),     32'(out_sends_max));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver pacing: free runs, short and long stalls, one long hold on request
  // --------------------------------------------------------------------------
  initial begin : receiver_pacing
    int r;
    int span;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        span = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 24);
        end else if (r < 88) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(8, 60);
        end
      end
      repeat (span - 1) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Offer one item after a random gap and wait until it is taken
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] flen,
                           input logic [NUM_W-1:0] ack, input logic [RND_W-1:0] rnd);
    int r;
    int gap;
    gap = 0;
    if (!no_gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 92)      gap = $urandom_range(6, 30);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_frame_length <= flen;
    in_ack_id       <= ack;
    in_random_value <= rnd;
    do @(posedge clk); while (in_stall);
    advance_link(mode, flen, ack, rnd);
  endtask

  // Stop offering and wait until every pending result is out or the wait limit is reached, plus pipe latency
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (link_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers written back to back; spare upper data bits on the slot write
  task automatic apply_settings(input logic [TMO_W-1:0] timeout, input logic [SLOT_W-1:0] slot);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= timeout;
    do @(posedge clk); while (!cfg_ready);
    timeout_setting = timeout;
    cfg_index <= CFG_SLOT;
    cfg_data  <= {8'($urandom), slot};
    do @(posedge clk); while (!cfg_ready);
    slot_setting = slot;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd1;
    if (r < 20) return 16'hFFFF;
    return LEN_W'($urandom_range(1, 65535));
  endfunction

  // Bias draws small so backoffs stay short, full range otherwise
  function automatic logic [RND_W-1:0] random_draw();
    if ($urandom_range(0, 1)) return RND_W'($urandom_range(0, 7));
    return RND_W'($urandom_range(0, 1023));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: one failure drawing a single slot of ten ticks
  task automatic test_reset_settings();
    send_item(MODE_FRAME, 16'hFFFF, 32'd0, 10'd0);
    send_item(MODE_ACK, 16'd1, 32'hFFFF_FFFF, 10'h3FF);
    repeat (10) send_item(MODE_TICK, 16'd1, 32'd0, 10'd0);
    send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
  endtask

  // Items the link ignores in its current phase, around one frame sent and delivered
  task automatic test_ignored_items();
    send_item(MODE_TICK, 16'd1, 32'd0, 10'h3FF);
    send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
    send_item(MODE_UNUSED, 16'h8000, 32'hFFFF_FFFF, 10'h3FF);
    send_item(MODE_FRAME, 16'd0, 32'd0, 10'd0);
    send_item(MODE_FRAME, 16'd1, 32'd0, 10'd0);
    send_item(MODE_FRAME, 16'hFFFF, 32'd0, 10'd0);
    send_item(MODE_TICK, 16'd1, 32'd0, 10'd0);
    send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
  endtask

  // Timeout and mismatch failures, then delivery on the third send
  task automatic test_retry_cycle();
    apply_settings(24'd1, 16'd0);
    send_item(MODE_FRAME, 16'h1234, 32'd0, 10'd0);
    send_item(MODE_TICK, 16'd1, 32'd0, 10'd1);
    send_item(MODE_TICK, 16'd1, 32'd0, 10'd0);
    send_item(MODE_UNUSED, 16'd1, frame_seq, 10'd0);
    send_item(MODE_ACK, 16'd1, frame_seq + 1, 10'd2);
    send_item(MODE_FRAME, 16'd7, 32'd0, 10'd0);
    send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
    send_item(MODE_TICK, 16'd1, 32'd0, 10'd0);
    send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
  endtask

  // Largest settings with a zero-slot draw: backoff ends on the first tick
  task automatic test_zero_slot_backoff();
    apply_settings(24'hFF_FFFF, 16'hFFFF);
    send_item(MODE_FRAME, 16'd9, 32'd0, 10'd0);
    send_item(MODE_ACK, 16'd1, ~frame_seq, 10'd0);
    send_item(MODE_TICK, 16'd1, 32'd0, 10'd0);
    send_item(MODE_TICK, 16'd1, 32'd0, 10'd0);
    send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
  endtask

  // Receiver holds off long while frames and acks keep coming
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    no_gaps = 1'b1;
    repeat (12) begin
      send_item(MODE_FRAME, random_length(), 32'd0, 10'd0);
      send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
    end
    no_gaps = 1'b0;
  endtask

  // One random item, mostly well formed for the current phase. A tenth
  // failure would abort for good, so at nine failures only the right ack goes.
  task automatic random_step(input bit huge_waits);
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  flen;
    logic [NUM_W-1:0]  ack;
    logic [RND_W-1:0]  rnd;
    int r;
    r = $urandom_range(0, 99);
    flen = random_length();
    ack  = $urandom();
    rnd  = random_draw();
    mode = MODE_TICK;
    if (r < 8 && fail_cnt < RETRY_LIMIT - 1) begin
      mode = MODE_W'($urandom_range(0, 3));
      flen = LEN_W'($urandom());
    end else begin
      case (link_state)
        ST_IDLE: mode = (r < 85) ? MODE_FRAME : MODE_TICK;
        ST_AWAIT_ACK: begin
          if (fail_cnt >= RETRY_LIMIT - 1 || r < 55) begin
            mode = MODE_ACK;
            ack = frame_seq;
          end else if (r < 70) begin
            mode = MODE_ACK;
            ack = frame_seq ^ ($urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
                                                    : ($urandom() | 32'd1));
          end else if (r < 95) begin
            mode = MODE_TICK;
          end else begin
            mode = MODE_FRAME;
          end
        end
        default: mode = (r < 92) ? MODE_TICK : ((r < 96) ? MODE_ACK : MODE_FRAME);
      endcase
    end
    if (huge_waits) rnd = '0;
    send_item(mode, flen, ack, rnd);
  endtask

  task automatic test_random_traffic();
    int  per_phase;
    bit  huge_waits;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      huge_waits = 1'b0;
      case (p)
        0: apply_settings(24'd5, 16'd1);
        1: apply_settings(24'd1, 16'd0);
        2: apply_settings(24'd24, 16'd3);
        3: begin
          apply_settings(24'hFF_FFFF, 16'hFFFF);
          huge_waits = 1'b1;
        end
        default: apply_settings(TMO_W'($urandom_range(1, 40)), SLOT_W'($urandom_range(0, 4)));
      endcase
      for (int i = 0; i < per_phase; i++) begin
        if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        random_step(huge_waits);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Ten failures end in abort; nothing gets through afterwards
  task automatic test_retry_abort();
    apply_settings(24'd1, 16'd0);
    while (link_state != ST_IDLE) begin
      if (link_state == ST_AWAIT_ACK) send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
      else                            send_item(MODE_TICK, 16'd1, 32'd0, 10'd0);
    end
    send_item(MODE_FRAME, 16'hFFFF, 32'd0, 10'd0);
    while (link_state != ST_ABORTED) begin
      if (link_state == ST_AWAIT_ACK && $urandom_range(0, 1))
        send_item(MODE_ACK, 16'd1, ~frame_seq, 10'h3FF);
      else
        send_item(MODE_TICK, 16'd1, 32'd0, 10'h3FF);
    end
    send_item(MODE_FRAME, 16'd100, 32'd0, 10'd0);
    send_item(MODE_ACK, 16'd1, frame_seq, 10'd0);
    send_item(MODE_TICK, 16'd1, 32'd0, 10'd0);
    send_item(MODE_UNUSED, 16'd1, 32'd0, 10'd0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_FRAME;
    in_frame_length <= '0;
    in_ack_id       <= '0;
    in_random_value <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_TIMEOUT;
    cfg_data        <= '0;

    link_state      = ST_IDLE;
    frame_seq       = '0;
    fail_cnt        = '0;
    ticks_left      = '0;
    frame_len       = '0;
    n_delivered     = '0;
    bytes_delivered = '0;
    tx_sum          = '0;
    tx_peak         = '0;
    timeout_setting = 24'd1000;
    slot_setting    = 16'd10;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_ignored_items();
    test_retry_cycle();
    test_zero_slot_backoff();
    test_output_backpressure();
    test_random_traffic();
    test_retry_abort();

    wait_for_drain();
    if (link_reports.size() != 0) begin
      mismatch_count += link_reports.size();
      $display("%0d predicted results never came out", link_reports.size());
    end
    if (mismatch_count == 0) begin
      $display("PASS stop_wait_retry_backoff_sender");
    end else begin
      $display("FAIL stop_wait_retry_backoff_sender");
    end
    $finish;
  end

  // Watchdog
  initial begin : run_limit
    #10_000_000;
    $display("FAIL stop_wait_retry_backoff_sender");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/swrb_pkg.sv
rtl/core/stop_wait_retry_backoff_sender.sv
tb/stop_wait_retry_backoff_sender_test.sv
